FILE: hdl/wrs_pkg.sv
// Shared types and constants for the weighted route selector.
// No dependencies; used by every module of the block by scoped name.
`default_nettype none

package wrs_pkg;

  // Default configuration of the router
  localparam int DEF_NUM_PORTS     = 8;
  localparam int DEF_NUM_NODES     = 64;
  localparam int DEF_WEIGHT_BITS   = 8;
  localparam int DEF_VC_COUNT_BITS = 3;

  // Fixed field widths of the input beat
  localparam int PORT_INDEX_W   = 3;
  localparam int ENTRY_MASK_W   = 64;
  localparam int ENTRY_WEIGHT_W = 8;
  localparam int DEST_MASK_W    = 64;
  localparam int FREE_VC_W      = 24;

  // Input tdata layout, lowest field first, padded to whole bytes
  localparam int PORT_INDEX_LSB   = 0;
  localparam int ENTRY_MASK_LSB   = PORT_INDEX_LSB + PORT_INDEX_W;
  localparam int ENTRY_WEIGHT_LSB = ENTRY_MASK_LSB + ENTRY_MASK_W;
  localparam int DEST_MASK_LSB    = ENTRY_WEIGHT_LSB + ENTRY_WEIGHT_W;
  localparam int FREE_VC_LSB      = DEST_MASK_LSB + DEST_MASK_W;
  localparam int IN_FIELDS_W      = FREE_VC_LSB + FREE_VC_W;
  localparam int IN_DATA_W        = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int IN_USER_W        = 1;

  // Output beat layout
  localparam int OUT_PORT_W  = 3;
  localparam int OUT_DATA_W  = 8;
  localparam int OUT_USER_W  = 1;

  // Counts beyond the free-VC field read as zero up to this width
  localparam int CNT_EXT_W = 64;

  // Operation codes carried in tuser
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_in;   // capture the accepted beat
    logic eval;      // table write, or match and least-weight step
    logic load_out;  // channel pick into the output register
  } wrs_cmd_t;

endpackage

`default_nettype wire

FILE: hdl/wrs_ctrl.sv
// Controller of the weighted route selector: sequencing and handshakes.
// Depends on wrs_pkg for the command struct.
`default_nettype none

module wrs_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output wrs_pkg::wrs_cmd_t     cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EVAL = 2'd1;
  localparam logic [1:0] ST_PICK = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;
  logic       accept;

  // Output register can take a result when empty or being drained
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == ST_IDLE) || ((state == ST_PICK) && out_free);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Drive datapath commands
  always_comb begin
    cmd          = '0;
    cmd.load_in  = accept;
    cmd.eval     = (state == ST_EVAL);
    cmd.load_out = (state == ST_PICK) && out_free;
  end

  // Advance the sequence
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_EVAL;
      end
      ST_EVAL: begin
        state_next = ST_PICK;
      end
      ST_PICK: begin
        if (out_free) state_next = accept ? ST_EVAL : ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      // Hold the result until the beat is taken
      if (cmd.load_out) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/wrs_datapath.sv
// Datapath of the weighted route selector: route table, match and
// least-weight step, free-channel pick and output register. Uses wrs_pkg.
`default_nettype none

module wrs_datapath #(
  parameter int NUM_PORTS     = wrs_pkg::DEF_NUM_PORTS,
  parameter int NUM_NODES     = wrs_pkg::DEF_NUM_NODES,
  parameter int WEIGHT_BITS   = wrs_pkg::DEF_WEIGHT_BITS,
  parameter int VC_COUNT_BITS = wrs_pkg::DEF_VC_COUNT_BITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire wrs_pkg::wrs_cmd_t              cmd,
  input  wire logic [wrs_pkg::IN_DATA_W-1:0]  s_tdata,
  input  wire logic [wrs_pkg::IN_USER_W-1:0]  s_tuser,
  output logic [wrs_pkg::OUT_PORT_W-1:0]      out_port,
  output logic                                no_route
);

  // Captured beat
  logic                                  in_op;
  logic [wrs_pkg::PORT_INDEX_W-1:0]      in_idx;
  logic [NUM_NODES-1:0]                  in_emask;
  logic [wrs_pkg::ENTRY_WEIGHT_W-1:0]    in_weight;
  logic [NUM_NODES-1:0]                  in_dest;
  logic [wrs_pkg::FREE_VC_W-1:0]         in_counts;

  // Route table
  logic [NUM_NODES-1:0]   route_masks  [NUM_PORTS];
  logic [WEIGHT_BITS-1:0] link_weights [NUM_PORTS];
  logic [NUM_PORTS-1:0]   entry_valid;

  // Stage registers between the two steps
  logic [NUM_PORTS-1:0] match_c;
  logic [NUM_PORTS-1:0] least_c;
  logic [NUM_PORTS-1:0] match_q;
  logic [NUM_PORTS-1:0] least_q;

  // Pick step
  logic [wrs_pkg::CNT_EXT_W-1:0] cnt_ext;
  logic [VC_COUNT_BITS-1:0]      vc_cnt [NUM_PORTS];
  logic [NUM_PORTS-1:0]          win_c;
  logic [wrs_pkg::OUT_PORT_W-1:0] enc_c;

  // Capture the accepted beat
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_op     <= s_tuser[0];
      in_idx    <= s_tdata[wrs_pkg::PORT_INDEX_LSB +: wrs_pkg::PORT_INDEX_W];
      in_emask  <= s_tdata[wrs_pkg::ENTRY_MASK_LSB +: NUM_NODES];
      in_weight <= s_tdata[wrs_pkg::ENTRY_WEIGHT_LSB +: wrs_pkg::ENTRY_WEIGHT_W];
      in_dest   <= s_tdata[wrs_pkg::DEST_MASK_LSB +: NUM_NODES];
      in_counts <= s_tdata[wrs_pkg::FREE_VC_LSB +: wrs_pkg::FREE_VC_W];
    end
  end

  // Program the table; ports the index cannot reach stay untouched
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (cmd.eval && (in_op == wrs_pkg::OP_WRITE)) begin
      for (int p = 0; p < NUM_PORTS; p++) begin
        if (int'(in_idx) == p) entry_valid[p] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval && (in_op == wrs_pkg::OP_WRITE)) begin
      for (int p = 0; p < NUM_PORTS; p++) begin
        if (int'(in_idx) == p) begin
          route_masks[p]  <= in_emask;
          link_weights[p] <= WEIGHT_BITS'(in_weight);
        end
      end
    end
  end

  // Match every valid port against the destination
  always_comb begin
    for (int p = 0; p < NUM_PORTS; p++) begin
      match_c[p] = entry_valid[p] && (|(route_masks[p] & in_dest));
    end
  end

  // Keep a matching port if no matching port is lighter
  always_comb begin
    for (int p = 0; p < NUM_PORTS; p++) begin
      least_c[p] = match_c[p];
      for (int q = 0; q < NUM_PORTS; q++) begin
        if (match_c[q] && (link_weights[q] < link_weights[p])) least_c[p] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      match_q <= match_c;
      least_q <= least_c;
    end
  end

  // Slice the free-channel counts; ports past the field read zero
  assign cnt_ext = wrs_pkg::CNT_EXT_W'(in_counts);

  always_comb begin
    for (int p = 0; p < NUM_PORTS; p++) begin
      vc_cnt[p] = cnt_ext[p*VC_COUNT_BITS +: VC_COUNT_BITS];
    end
  end

  // Most free channels wins, lower index takes a tie
  always_comb begin
    for (int p = 0; p < NUM_PORTS; p++) begin
      win_c[p] = least_q[p];
      for (int q = 0; q < NUM_PORTS; q++) begin
        if (q < p) begin
          if (least_q[q] && (vc_cnt[q] >= vc_cnt[p])) win_c[p] = 1'b0;
        end else if (q > p) begin
          if (least_q[q] && (vc_cnt[q] > vc_cnt[p])) win_c[p] = 1'b0;
        end
      end
    end
  end

  // Encode the one-hot winner, keeping the low index bits
  always_comb begin
    enc_c = '0;
    for (int p = 0; p < NUM_PORTS; p++) begin
      if (win_c[p]) enc_c = enc_c | wrs_pkg::OUT_PORT_W'(p);
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (in_op == wrs_pkg::OP_LOOKUP) begin
        out_port <= (|match_q) ? enc_c : '0;
        no_route <= ~(|match_q);
      end else begin
        out_port <= '0;
        no_route <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/weighted_route_select.sv
// Top level of the weighted route selector: stream ports, controller and
// datapath. Depends on wrs_pkg, wrs_ctrl and wrs_datapath.
`default_nettype none

// Table-driven output-port selector for a network-on-chip router. A write
// beat (tuser op = 0) stores one port's destination mask and link weight
// and marks the entry valid; a lookup beat (op = 1) returns, among valid
// ports whose mask meets the destination, the least-weight port with the
// most free virtual channels, lowest index on a tie, or raises no_route.
// Every beat gives exactly one result. After a beat is accepted, a match
// step matches the table and finds the least weight into the stage
// registers, then a pick step picks on free channels and loads the output
// register; the next beat is taken in that same pick cycle, and none is
// taken during the match step. A full output register that is not drained
// holds the pick step and so holds the input side.

module weighted_route_select #(
  parameter int NUM_PORTS     = wrs_pkg::DEF_NUM_PORTS,
  parameter int NUM_NODES     = wrs_pkg::DEF_NUM_NODES,
  parameter int WEIGHT_BITS   = wrs_pkg::DEF_WEIGHT_BITS,
  parameter int VC_COUNT_BITS = wrs_pkg::DEF_VC_COUNT_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // port_index[2:0], entry_mask[66:3], entry_weight[74:67],
  // dest_mask[138:75], free_vc_counts[162:139], zero pad[167:163]
  input  wire logic [wrs_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // op[0]
  input  wire logic [wrs_pkg::IN_USER_W-1:0]   s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // out_port[2:0], zero pad[7:3]
  output logic [wrs_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  // no_route[0]
  output logic [wrs_pkg::OUT_USER_W-1:0]       m_axis_tuser
);

  wrs_pkg::wrs_cmd_t                cmd;
  logic [wrs_pkg::OUT_PORT_W-1:0]   out_port;
  logic                             no_route;

  wrs_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cmd           (cmd)
  );

  wrs_datapath #(
    .NUM_PORTS     (NUM_PORTS),
    .NUM_NODES     (NUM_NODES),
    .WEIGHT_BITS   (WEIGHT_BITS),
    .VC_COUNT_BITS (VC_COUNT_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .s_tdata  (s_axis_tdata),
    .s_tuser  (s_axis_tuser),
    .out_port (out_port),
    .no_route (no_route)
  );

  // Pack the result beat
  assign m_axis_tdata = wrs_pkg::OUT_DATA_W'(out_port);
  assign m_axis_tuser = wrs_pkg::OUT_USER_W'(no_route);

endmodule

`default_nettype wire

FILE: hdl/wrs_checker.sv
// Port-level checks for the weighted route selector, bound to the top
// level. Depends on wrs_pkg and weighted_route_select.
`default_nettype none

module wrs_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            s_axis_tvalid,
  input wire logic                            s_axis_tready,
  input wire logic [wrs_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  input wire logic [wrs_pkg::IN_USER_W-1:0]   s_axis_tuser,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready,
  input wire logic [wrs_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input wire logic [wrs_pkg::OUT_USER_W-1:0]  m_axis_tuser
);

  // Stalled result beat holds
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // A missing route reports port zero
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[wrs_pkg::OUT_PORT_W-1:0] == '0)
    else $error("no_route with a non-zero port");

  // The match step always follows an accepted beat
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready during the match step");

  // A new result follows a match step and then a pick step
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready, 2))
    else $error("result appeared without a match step");

endmodule

bind weighted_route_select wrs_checker u_wrs_checker (.*);

`default_nettype wire

FILE: tb/tb_weighted_route_select.sv
// Self-checking testbench for weighted_route_select: directed table writes and
// lookups, then random traffic under varied stalls, checked beat by beat.
// Depends on wrs_pkg and weighted_route_select only.
`timescale 1ns / 100ps

module tb_weighted_route_select;

  localparam int NPORTS         = wrs_pkg::DEF_NUM_PORTS;
  localparam int VCW            = wrs_pkg::DEF_VC_COUNT_BITS;
  localparam int ITEMS_PER_PASS = 325;
  localparam int HOLD_CYCLES    = 40;
  localparam int TAIL_CYCLES    = 20;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int REPORT_LIMIT   = 10;

  // Expected result of one beat
  typedef struct packed {
    logic [wrs_pkg::OUT_PORT_W-1:0] port;
    logic                           no_route;
  } route_t;

  // One directed stimulus row; known marks a result typed in by hand
  typedef struct packed {
    logic                               op;
    logic [wrs_pkg::PORT_INDEX_W-1:0]   port;
    logic [wrs_pkg::ENTRY_MASK_W-1:0]   emask;
    logic [wrs_pkg::ENTRY_WEIGHT_W-1:0] weight;
    logic [wrs_pkg::DEST_MASK_W-1:0]    dest;
    logic [wrs_pkg::FREE_VC_W-1:0]      counts;
    logic                               known;
    route_t                             result;
  } stim_row_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_axis_tvalid = 1'b0;
  wire logic                      s_axis_tready;
  // port_index, entry_mask, entry_weight, dest_mask, free_vc_counts, zero pad
  logic [wrs_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  // op
  logic [wrs_pkg::IN_USER_W-1:0]  s_axis_tuser = '0;
  wire logic                      m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  // out_port, zero pad
  wire logic [wrs_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  // no_route
  wire logic [wrs_pkg::OUT_USER_W-1:0] m_axis_tuser;

  // Shadow routing table
  logic [wrs_pkg::ENTRY_MASK_W-1:0]   shadow_mask   [NPORTS];
  logic [wrs_pkg::ENTRY_WEIGHT_W-1:0] shadow_weight [NPORTS];
  logic                               shadow_valid  [NPORTS];

  route_t    expected_routes[$];
  stim_row_t directed_rows[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_req       = 1'b0;
  int hold_left      = 0;
  int mismatch_count = 0;
  int n_writes       = 0;
  int n_lookups      = 0;
  int n_no_route     = 0;
  int n_results      = 0;
  int n_holds        = 0;

  weighted_route_select u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Clock and reset
  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  // Apply one accepted beat to the shadow table and return its result
  function automatic route_t predict_route(logic op,
                                           logic [wrs_pkg::PORT_INDEX_W-1:0] port,
                                           logic [wrs_pkg::ENTRY_MASK_W-1:0] emask,
                                           logic [wrs_pkg::ENTRY_WEIGHT_W-1:0] weight,
                                           logic [wrs_pkg::DEST_MASK_W-1:0] dest,
                                           logic [wrs_pkg::FREE_VC_W-1:0] counts);
    route_t                             r;
    logic                               hit;
    logic [wrs_pkg::ENTRY_WEIGHT_W-1:0] least;
    logic [VCW-1:0]                     best_cnt;
    logic [VCW-1:0]                     cnt;
    r     = '0;
    hit   = 1'b0;
    least = '0;
    if (op == wrs_pkg::OP_WRITE) begin
      shadow_mask[port]   = emask;
      shadow_weight[port] = weight;
      shadow_valid[port]  = 1'b1;
      return r;
    end
    // least weight among valid ports that reach the destination
    for (int p = 0; p < NPORTS; p++) begin
      if (shadow_valid[p] && (shadow_mask[p] & dest) != '0) begin
        if (!hit || shadow_weight[p] < least) least = shadow_weight[p];
        hit = 1'b1;
      end
    end
    if (!hit) begin
      r.no_route = 1'b1;
      return r;
    end
    // most free channels at that weight, lowest index keeps a tie
    hit      = 1'b0;
    best_cnt = '0;
    for (int p = 0; p < NPORTS; p++) begin
      cnt = counts[p*VCW +: VCW];
      if (shadow_valid[p] && (shadow_mask[p] & dest) != '0 &&
          shadow_weight[p] == least && (!hit || cnt > best_cnt)) begin
        best_cnt = cnt;
        r.port   = wrs_pkg::OUT_PORT_W'(p);
        hit      = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) $display("%0t ns: %s", $time, msg);
  endtask

  // Offer one beat, wait for it to be taken, then record what it should give
  task automatic send_beat(stim_row_t row);
    logic [wrs_pkg::IN_DATA_W-1:0] data;
    route_t                        r;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    data = '0;
    data[wrs_pkg::PORT_INDEX_LSB +: wrs_pkg::PORT_INDEX_W]     = row.port;
    data[wrs_pkg::ENTRY_MASK_LSB +: wrs_pkg::ENTRY_MASK_W]     = row.emask;
    data[wrs_pkg::ENTRY_WEIGHT_LSB +: wrs_pkg::ENTRY_WEIGHT_W] = row.weight;
    data[wrs_pkg::DEST_MASK_LSB +: wrs_pkg::DEST_MASK_W]       = row.dest;
    data[wrs_pkg::FREE_VC_LSB +: wrs_pkg::FREE_VC_W]           = row.counts;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= row.op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    r = predict_route(row.op, row.port, row.emask, row.weight, row.dest, row.counts);
    expected_routes = {expected_routes, (row.known ? row.result : r)};
    if (row.op == wrs_pkg::OP_WRITE) n_writes++;
    else n_lookups++;
  endtask

  // Pause the sender until every expected result has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_routes.size() != 0) @(posedge clk);
  endtask

  task automatic add_row(logic op, logic [wrs_pkg::PORT_INDEX_W-1:0] port,
                         logic [wrs_pkg::ENTRY_MASK_W-1:0] emask,
                         logic [wrs_pkg::ENTRY_WEIGHT_W-1:0] weight,
                         logic [wrs_pkg::DEST_MASK_W-1:0] dest,
                         logic [wrs_pkg::FREE_VC_W-1:0] counts,
                         logic known, logic [wrs_pkg::OUT_PORT_W-1:0] exp_port,
                         logic exp_nr);
    stim_row_t row;
    row.op              = op;
    row.port            = port;
    row.emask           = emask;
    row.weight          = weight;
    row.dest            = dest;
    row.counts          = counts;
    row.known           = known;
    row.result.port     = exp_port;
    row.result.no_route = exp_nr;
    directed_rows = {directed_rows, row};
  endtask

  // Masks: a low byte for overlaps, full random, one node, or all/none
  function automatic logic [63:0] draw_mask();
    logic [63:0] m;
    case ($urandom_range(3))
      0:       m = {56'd0, 8'($urandom)};
      1:       m = {$urandom, $urandom};
      2:       m = 64'd1 << $urandom_range(63);
      default: m = $urandom_range(1) ? {64{1'b1}} : 64'd0;
    endcase
    return m;
  endfunction

  task automatic send_random_item();
    stim_row_t row;
    row        = '0;
    row.op     = ($urandom_range(99) < 25) ? wrs_pkg::OP_WRITE : wrs_pkg::OP_LOOKUP;
    row.port   = wrs_pkg::PORT_INDEX_W'($urandom);
    row.emask  = draw_mask();
    // narrow weights often, so that ties on weight come up
    row.weight = $urandom_range(1) ? wrs_pkg::ENTRY_WEIGHT_W'($urandom_range(3))
                                   : wrs_pkg::ENTRY_WEIGHT_W'($urandom);
    row.dest   = draw_mask();
    row.counts = wrs_pkg::FREE_VC_W'($urandom);
    send_beat(row);
  endtask

  // Check output beats and drive the receiver's ready
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (m_axis_tuser[0]) n_no_route++;
      if (expected_routes.size() == 0) begin
        note_mismatch($sformatf("result with nothing expected: port %0d no_route %0b",
                                m_axis_tdata[wrs_pkg::OUT_PORT_W-1:0], m_axis_tuser[0]));
      end else begin
        route_t want;
        want = expected_routes.pop_front();
        if (m_axis_tdata !== wrs_pkg::OUT_DATA_W'(want.port))
          note_mismatch($sformatf("out_port: expected %0d, got tdata 0x%0h",
                                  want.port, m_axis_tdata));
        if (m_axis_tuser[0] !== want.no_route)
          note_mismatch($sformatf("no_route: expected %0b, got %0b",
                                  want.no_route, m_axis_tuser[0]));
      end
    end
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      n_holds++;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: end the run after a long stretch with no beat on either side
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("Timeout: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  // Stimulus
  initial begin : stimulus
    int pass_stall [4];
    int pass_idle  [4];
    pass_idle  = '{0, 62, 0, 36};
    pass_stall = '{0, 0, 62, 36};
    for (int p = 0; p < NPORTS; p++) begin
      shadow_mask[p]   = '0;
      shadow_weight[p] = '0;
      shadow_valid[p]  = 1'b0;
    end

    // lookup on an empty table, then extremes, rewrites and ties
    add_row(wrs_pkg::OP_LOOKUP, 3'd0, 64'd0, 8'd0, {64{1'b1}}, 24'hFFFFFF,
            1'b1, 3'd0, 1'b1);
    add_row(wrs_pkg::OP_WRITE, 3'd0, {64{1'b1}}, 8'd255, 64'd0, 24'd0, 1'b1, 3'd0, 1'b0);
    add_row(wrs_pkg::OP_LOOKUP, 3'd0, 64'd0, 8'd0, 64'd1, 24'd0, 1'b0, 3'd0, 1'b0);
    add_row(wrs_pkg::OP_WRITE, 3'd7, 64'h8000_0000_0000_0001, 8'd0, 64'd0, 24'd0,
            1'b1, 3'd0, 1'b0);
    add_row(wrs_pkg::OP_LOOKUP, 3'd0, 64'd0, 8'd0, 64'h8000_0000_0000_0000, 24'hFFFFFF,
            1'b0, 3'd0, 1'b0);
    // a valid entry with an empty mask never matches
    add_row(wrs_pkg::OP_WRITE, 3'd3, 64'd0, 8'd0, 64'd0, 24'd0, 1'b1, 3'd0, 1'b0);
    add_row(wrs_pkg::OP_LOOKUP, 3'd0, 64'd0, 8'd0, {64{1'b1}}, 24'hFFFFFF,
            1'b0, 3'd0, 1'b0);
    add_row(wrs_pkg::OP_WRITE, 3'd1, 64'hFF, 8'd0, 64'd0, 24'd0, 1'b1, 3'd0, 1'b0);
    add_row(wrs_pkg::OP_LOOKUP, 3'd0, 64'd0, 8'd0, 64'd1, 24'd0, 1'b0, 3'd0, 1'b0);
    add_row(wrs_pkg::OP_LOOKUP, 3'd0, 64'd0, 8'd0, 64'd1, 24'hE00000, 1'b0, 3'd0, 1'b0);
    add_row(wrs_pkg::OP_WRITE, 3'd2, 64'd1, 8'd0, 64'd0, 24'd0, 1'b1, 3'd0, 1'b0);
    add_row(wrs_pkg::OP_WRITE, 3'd4, 64'd1, 8'd0, 64'd0, 24'd0, 1'b1, 3'd0, 1'b0);
    add_row(wrs_pkg::OP_LOOKUP, 3'd0, 64'd0, 8'd0, 64'd1, 24'hA05158, 1'b0, 3'd0, 1'b0);
    add_row(wrs_pkg::OP_LOOKUP, 3'd0, 64'd0, 8'd0, 64'h100, 24'h000000, 1'b0, 3'd0, 1'b0);
    // an empty destination set has no route
    add_row(wrs_pkg::OP_LOOKUP, 3'd0, 64'd0, 8'd0, 64'd0, 24'hFFFFFF, 1'b1, 3'd0, 1'b1);
    add_row(wrs_pkg::OP_WRITE, 3'd0, 64'd0, 8'd1, 64'd0, 24'd0, 1'b1, 3'd0, 1'b0);
    add_row(wrs_pkg::OP_LOOKUP, 3'd0, 64'd0, 8'd0, 64'h100, 24'hFFFFFF, 1'b0, 3'd0, 1'b0);
    add_row(wrs_pkg::OP_WRITE, 3'd5, {64{1'b1}}, 8'd255, 64'd0, 24'd0, 1'b1, 3'd0, 1'b0);
    add_row(wrs_pkg::OP_WRITE, 3'd6, 64'hFFFF_0000_0000_0000, 8'd254, 64'd0, 24'd0,
            1'b1, 3'd0, 1'b0);
    add_row(wrs_pkg::OP_LOOKUP, 3'd0, 64'd0, 8'd0, 64'h4000_0000_0000_0000, 24'hFFFFFF,
            1'b0, 3'd0, 1'b0);
    add_row(wrs_pkg::OP_LOOKUP, 3'd0, 64'd0, 8'd0, 64'h8000_0000_0000_0000, 24'h000000,
            1'b0, 3'd0, 1'b0);
    add_row(wrs_pkg::OP_WRITE, 3'd7, 64'd0, 8'd255, 64'd0, 24'd0, 1'b1, 3'd0, 1'b0);
    add_row(wrs_pkg::OP_WRITE, 3'd6, 64'hFFFF_0000_0000_0000, 8'd255, 64'd0, 24'd0,
            1'b1, 3'd0, 1'b0);
    add_row(wrs_pkg::OP_LOOKUP, 3'd0, 64'd0, 8'd0, 64'h8000_0000_0000_0000, 24'h0D8000,
            1'b0, 3'd0, 1'b0);
    add_row(wrs_pkg::OP_LOOKUP, 3'd0, 64'd0, 8'd0, 64'h8000_0000_0000_0000, 24'h1C0000,
            1'b0, 3'd0, 1'b0);

    @(posedge clk);
    while (rst) @(posedge clk);

    foreach (directed_rows[i]) send_beat(directed_rows[i]);
    drain_results();

    // random traffic, one pass per stall setting
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = pass_idle[ph];
      recv_stall_pct = pass_stall[ph];
      // hold the receiver off while the sender keeps offering beats
      if (ph == 0) hold_req = 1'b1;
      for (int n = 0; n < ITEMS_PER_PASS; n++) send_random_item();
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_routes.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", expected_routes.size()));

    $display("Run covered %0d table writes and %0d lookups, %0d results (%0d no_route).",
             n_writes, n_lookups, n_results, n_no_route);
    $display("Stall passes: none, sender, receiver, both; %0d long receiver hold-off(s).",
             n_holds);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
